FILE: rtl/stc_pkg.sv
`default_nettype none

package stc_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_STRING = 3'd3,
        MODE_CMP    = 3'd4
    } scan_mode_t;

    typedef enum logic [4:0] {
        TOK_VAR     = 5'd0,
        TOK_PRINT   = 5'd1,
        TOK_IF      = 5'd2,
        TOK_ELSE    = 5'd3,
        TOK_RETURN  = 5'd4,
        TOK_ID      = 5'd5,
        TOK_NUMBER  = 5'd6,
        TOK_STRING  = 5'd7,
        TOK_OP      = 5'd8,
        TOK_COMPARE = 5'd9,
        TOK_ASSIGN  = 5'd10,
        TOK_LPAREN  = 5'd11,
        TOK_RPAREN  = 5'd12,
        TOK_LBRACE  = 5'd13,
        TOK_RBRACE  = 5'd14,
        TOK_SEMI    = 5'd15,
        TOK_END     = 5'd16
    } tok_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_ILLEGAL = 2'd1,
        ERR_UNTERM  = 2'd2
    } err_t;

    localparam logic KIND_TOKEN = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    localparam int RES_SLOTS = 3;

    localparam logic [47:0] KW_VAR_TEXT    = 48'h000000766172;
    localparam logic [47:0] KW_PRINT_TEXT  = 48'h007072696E74;
    localparam logic [47:0] KW_IF_TEXT     = 48'h000000006966;
    localparam logic [47:0] KW_ELSE_TEXT   = 48'h0000656C7365;
    localparam logic [47:0] KW_RETURN_TEXT = 48'h72657475726E;

    typedef struct packed {
        logic        kind;
        tok_t        ttype;
        err_t        err;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic [7:0]  bad;
    } res_t;

    typedef struct packed {
        logic [1:0]               count;
        res_t [RES_SLOTS-1:0]     slot;
    } batch_t;

endpackage

`default_nettype wire

FILE: rtl/source_char_tokenizer.sv
`default_nettype none

// Channel   Direction  tdata                 tuser       tlast
// s_        in         char_byte [7:0]       -           end_of_source
// m_        out        token/error fields    item_kind   last_of_run
//
// One source byte is taken per cycle unless the m_ side stalls; an input register
// holds the byte while the scan logic forms up to three results, which load into the
// result register. Results leave one per cycle while m_tready is high, and the next
// byte is taken as the last of them is transferred.
// Reset is synchronous on aresetn and returns the scanner to the start of a source.
// A stalled m_ side holds the pending byte in the input register and drops s_tready.
module source_char_tokenizer #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_byte [7:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // token_type [4:0], error_code [6:5], line_number [22:7], column [38:23],
    // token_length [54:39], bad_byte [62:55], zero [63]
    output logic [63:0]      m_tdata,
    output logic [0:0]       m_tuser,   // item_kind [0]
    output logic             m_tlast
);
    import stc_pkg::*;

    batch_t batch;
    logic   batch_load;
    logic   q_free;
    res_t   out_res;

    stc_scan_core #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_eos     (s_tlast),
        .q_free     (q_free),
        .batch      (batch),
        .batch_load (batch_load)
    );

    stc_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .batch      (batch),
        .batch_load (batch_load),
        .q_free     (q_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res),
        .out_last   (m_tlast)
    );

    assign m_tdata = {1'b0, out_res.bad, out_res.len, out_res.col, out_res.line,
                      out_res.err, out_res.ttype};
    assign m_tuser = out_res.kind;

endmodule

`default_nettype wire

FILE: rtl/stc_scan_core.sv
`default_nettype none

module stc_scan_core #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_eos,
    input  wire logic           q_free,
    output stc_pkg::batch_t     batch,
    output logic                batch_load
);
    import stc_pkg::*;

    localparam int CB = COUNTER_BITS;
    localparam int WW = (CB > 16) ? CB : 16;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};
    localparam logic [CB-1:0] CONE = CB'(1);

    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            in_eos_reg;
    logic            fire;

    scan_mode_t      mode_reg, mode_next;
    logic [CB-1:0]   ts_reg, ts_next;
    logic [CB-1:0]   pos_reg, pos_next;
    logic [CB-1:0]   ls_reg, ls_next;
    logic [CB-1:0]   line_reg, line_next;
    logic [47:0]     prefix_reg, prefix_next;
    logic [2:0]      plen_reg, plen_next;
    logic [7:0]      pend_reg, pend_next;

    logic            a_v, bc_v, end_v, consumed;
    res_t            a_res, bc_res, end_res;
    logic [7:0]      c;
    logic [CB-1:0]   p;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v == CMAX) ? CMAX : v + CONE;
    endfunction

    function automatic logic [15:0] clamp16(input logic [CB-1:0] v);
        logic [WW-1:0] w;
        w = WW'(v);
        return (w > WW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic tok_t ident_type(input logic [47:0] pre, input logic [2:0] len);
        tok_t t;
        priority if (len == 3'd3 && pre == KW_VAR_TEXT) t = TOK_VAR;
        else if (len == 3'd5 && pre == KW_PRINT_TEXT) t = TOK_PRINT;
        else if (len == 3'd2 && pre == KW_IF_TEXT) t = TOK_IF;
        else if (len == 3'd4 && pre == KW_ELSE_TEXT) t = TOK_ELSE;
        else if (len == 3'd6 && pre == KW_RETURN_TEXT) t = TOK_RETURN;
        else t = TOK_ID;
        return t;
    endfunction

    function automatic res_t mk_res(input logic kind, input tok_t tt, input err_t e,
                                    input logic [CB-1:0] ln, input logic [15:0] col,
                                    input logic [15:0] len, input logic [7:0] b);
        res_t r;
        r.kind  = kind;
        r.ttype = tt;
        r.err   = e;
        r.line  = clamp16(ln);
        r.col   = col;
        r.len   = len;
        r.bad   = b;
        return r;
    endfunction

    function automatic res_t mk_pending(input scan_mode_t m, input logic [47:0] pre,
                                        input logic [2:0] plen, input logic [7:0] pend,
                                        input logic [CB-1:0] ln, input logic [CB-1:0] ts,
                                        input logic [CB-1:0] ls, input logic [CB-1:0] endp);
        res_t r;
        logic [15:0] col;
        logic [15:0] len;
        col = clamp16(ts - ls);
        len = clamp16(endp - ts);
        unique case (m)
            MODE_IDENT:  r = mk_res(KIND_TOKEN, ident_type(pre, plen), ERR_NONE, ln, col, len,
                                    8'd0);
            MODE_NUMBER: r = mk_res(KIND_TOKEN, TOK_NUMBER, ERR_NONE, ln, col, len, 8'd0);
            MODE_CMP:    r = mk_res(KIND_TOKEN, (pend == "=") ? TOK_ASSIGN : TOK_COMPARE,
                                    ERR_NONE, ln, col, 16'd1, 8'd0);
            MODE_STRING: r = mk_res(KIND_ERROR, TOK_VAR, ERR_UNTERM, ln, col, len, 8'd0);
            default:     r = mk_res(KIND_TOKEN, TOK_END, ERR_NONE, ln, 16'd0, 16'd0, 8'd0);
        endcase
        return r;
    endfunction

    assign fire     = in_valid_reg && q_free;
    assign in_ready = !in_valid_reg || q_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            in_byte_reg <= in_byte;
            in_eos_reg  <= in_eos;
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        ts_next     = ts_reg;
        pos_next    = pos_reg;
        ls_next     = ls_reg;
        line_next   = line_reg;
        prefix_next = prefix_reg;
        plen_next   = plen_reg;
        pend_next   = pend_reg;
        consumed    = 1'b0;
        a_v         = 1'b0;
        bc_v        = 1'b0;
        end_v       = 1'b0;
        c           = in_byte_reg;
        p           = pos_reg;
        a_res       = mk_res(KIND_TOKEN, TOK_END, ERR_NONE, line_reg, 16'd0, 16'd0, 8'd0);
        bc_res      = a_res;
        end_res     = a_res;

        unique case (mode_reg)
            MODE_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    if (plen_reg < 3'd6) prefix_next = {prefix_reg[39:0], c};
                    if (plen_reg < 3'd7) plen_next = plen_reg + 3'd1;
                    consumed = 1'b1;
                end else begin
                    a_v = 1'b1;
                    a_res = mk_pending(mode_reg, prefix_reg, plen_reg, pend_reg, line_reg,
                                       ts_reg, ls_reg, p);
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(c)) begin
                    consumed = 1'b1;
                end else begin
                    a_v = 1'b1;
                    a_res = mk_pending(mode_reg, prefix_reg, plen_reg, pend_reg, line_reg,
                                       ts_reg, ls_reg, p);
                    mode_next = MODE_IDLE;
                end
            end
            MODE_CMP: begin
                a_v = 1'b1;
                mode_next = MODE_IDLE;
                if (c == "=") begin
                    a_res = mk_res(KIND_TOKEN, TOK_COMPARE, ERR_NONE, line_reg,
                                   clamp16(ts_reg - ls_reg), 16'd2, 8'd0);
                    consumed = 1'b1;
                end else begin
                    a_res = mk_pending(mode_reg, prefix_reg, plen_reg, pend_reg, line_reg,
                                       ts_reg, ls_reg, p);
                end
            end
            MODE_STRING: begin
                if (c == "\"") begin
                    a_v = 1'b1;
                    a_res = mk_res(KIND_TOKEN, TOK_STRING, ERR_NONE, line_reg,
                                   clamp16(ts_reg - ls_reg), clamp16(p - ts_reg), 8'd0);
                    mode_next = MODE_IDLE;
                end
                consumed = 1'b1;
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (!consumed) begin
            bc_res = mk_res(KIND_TOKEN, TOK_OP, ERR_NONE, line_reg, clamp16(p - ls_reg),
                            16'd1, 8'd0);
            priority if (c == " " || (c >= 8'h09 && c <= 8'h0D)) begin
                if (c == 8'h0A) begin
                    line_next = sat_inc(line_reg);
                    ls_next   = sat_inc(p);
                end
            end else if (is_alpha(c) || c == "_") begin
                mode_next   = MODE_IDENT;
                ts_next     = p;
                prefix_next = {40'd0, c};
                plen_next   = 3'd1;
            end else if (is_digit(c)) begin
                mode_next = MODE_NUMBER;
                ts_next   = p;
            end else if (c == "\"") begin
                mode_next = MODE_STRING;
                ts_next   = sat_inc(p);
            end else if (c == "+" || c == "-" || c == "*" || c == "/") begin
                bc_v = 1'b1;
            end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
                mode_next = MODE_CMP;
                ts_next   = p;
                pend_next = c;
            end else if (c == "(") begin
                bc_v = 1'b1;
                bc_res.ttype = TOK_LPAREN;
            end else if (c == ")") begin
                bc_v = 1'b1;
                bc_res.ttype = TOK_RPAREN;
            end else if (c == "{") begin
                bc_v = 1'b1;
                bc_res.ttype = TOK_LBRACE;
            end else if (c == "}") begin
                bc_v = 1'b1;
                bc_res.ttype = TOK_RBRACE;
            end else if (c == ";") begin
                bc_v = 1'b1;
                bc_res.ttype = TOK_SEMI;
            end else begin
                bc_v = 1'b1;
                bc_res.kind  = KIND_ERROR;
                bc_res.ttype = TOK_VAR;
                bc_res.err   = ERR_ILLEGAL;
                bc_res.bad   = c;
            end
        end

        pos_next = sat_inc(p);

        if (in_eos_reg) begin
            if (mode_next != MODE_IDLE) begin
                bc_v = 1'b1;
                bc_res = mk_pending(mode_next, prefix_next, plen_next, pend_next, line_next,
                                    ts_next, ls_next, pos_next);
            end
            end_v   = 1'b1;
            end_res = mk_res(KIND_TOKEN, TOK_END, ERR_NONE, line_next, 16'd0, 16'd0, 8'd0);
            mode_next   = MODE_IDLE;
            ts_next     = '0;
            pos_next    = '0;
            ls_next     = '0;
            line_next   = CONE;
            prefix_next = '0;
            plen_next   = '0;
            pend_next   = '0;
        end

        batch.count   = 2'({1'b0, a_v} + {1'b0, bc_v} + {1'b0, end_v});
        batch.slot[0] = a_v ? a_res : (bc_v ? bc_res : end_res);
        batch.slot[1] = a_v ? (bc_v ? bc_res : end_res) : end_res;
        batch.slot[2] = end_res;
    end

    assign batch_load = fire && (batch.count != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            ts_reg     <= '0;
            pos_reg    <= '0;
            ls_reg     <= '0;
            line_reg   <= CONE;
            prefix_reg <= '0;
            plen_reg   <= '0;
            pend_reg   <= '0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            ts_reg     <= ts_next;
            pos_reg    <= pos_next;
            ls_reg     <= ls_next;
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
            plen_reg   <= plen_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/stc_result_queue.sv
`default_nettype none

module stc_result_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire stc_pkg::batch_t batch,
    input  wire logic           batch_load,
    output logic                q_free,
    output logic                out_valid,
    input  wire logic           out_ready,
    output stc_pkg::res_t       out_res,
    output logic                out_last
);
    import stc_pkg::*;

    batch_t      batch_reg;
    logic [1:0]  rem_reg;
    logic [1:0]  idx_reg;

    assign out_valid = (rem_reg != 2'd0);
    assign out_last  = (rem_reg == 2'd1);
    assign out_res   = batch_reg.slot[idx_reg];
    assign q_free    = (rem_reg == 2'd0) || (rem_reg == 2'd1 && out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (batch_load) begin
            rem_reg <= batch.count;
            idx_reg <= 2'd0;
        end else if (out_valid && out_ready) begin
            rem_reg <= rem_reg - 2'd1;
            idx_reg <= idx_reg + 2'd1;
        end
        if (batch_load) begin
            batch_reg <= batch;
        end
    end

endmodule

`default_nettype wire
